### hw/rtl/fbdp_pkg.sv
package fbdp_pkg;

	localparam int CFG_W   = 7;
	localparam int COORD_W = 7;
	localparam int BND_W   = 11;
	localparam int SQ_W    = 16;
	localparam int COUNT_W = 13;
	localparam int PIX_W   = 32;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_DISC  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	localparam logic REG_CANVAS_WIDTH  = 1'b0;
	localparam logic REG_CANVAS_HEIGHT = 1'b1;

	typedef struct packed {
		logic wipe;
		logic load;
		logic setup;
		logic scan;
		logic rd;
		logic finish;
	} fbdp_cmd_t;

	typedef struct packed {
		logic wipe_last;
		logic scan_go;
		logic read_go;
		logic scan_last;
		logic out_free;
	} fbdp_sts_t;

endpackage

### hw/rtl/fbdp_ctrl.sv
module fbdp_ctrl import fbdp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  fbdp_sts_t sts,
	output fbdp_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_WIPE,
		ST_IDLE,
		ST_SETUP,
		ST_SCAN,
		ST_DRAIN,
		ST_READ,
		ST_DONE
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_WIPE;
		end else begin
			unique case (state_q)
				ST_WIPE: begin
					if (sts.wipe_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					if (sts.scan_go) begin
						state_q <= ST_SCAN;
					end else if (sts.read_go) begin
						state_q <= ST_READ;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_SCAN: begin
					if (sts.scan_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_READ: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd        = '0;
		cmd.wipe   = (state_q == ST_WIPE);
		cmd.load   = (state_q == ST_IDLE) && in_valid;
		cmd.setup  = (state_q == ST_SETUP);
		cmd.scan   = (state_q == ST_SCAN);
		cmd.rd     = (state_q == ST_READ);
		cmd.finish = (state_q == ST_DONE) && sts.out_free;
	end

endmodule

### hw/rtl/fbdp_datapath.sv
module fbdp_datapath import fbdp_pkg::*; #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  fbdp_cmd_t          cmd,
	output fbdp_sts_t          sts,
	input  logic [CFG_W-1:0]   canvas_width,
	input  logic [CFG_W-1:0]   canvas_height,
	input  logic [1:0]         op,
	input  logic signed [8:0]  center_x,
	input  logic signed [8:0]  center_y,
	input  logic signed [8:0]  radius,
	input  logic [7:0]         paint_red,
	input  logic [7:0]         paint_green,
	input  logic [7:0]         paint_blue,
	input  logic [7:0]         paint_alpha,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [7:0]         pixel_red,
	output logic [7:0]         pixel_green,
	output logic [7:0]         pixel_blue,
	output logic [7:0]         pixel_alpha,
	output logic               pixel_valid,
	output logic [COUNT_W-1:0] pixels_written
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [PIX_W-1:0] mem [DEPTH];

	logic [1:0]         op_q;
	logic signed [8:0]  cx_q;
	logic signed [8:0]  cy_q;
	logic signed [8:0]  rad_q;
	logic [PIX_W-1:0]   colour_q;

	logic [COORD_W-1:0] x_q, y_q, x0_q, x1_q, y1_q;
	logic [SQ_W-1:0]    r2_q;
	logic               rd_ok_q;
	logic [COUNT_W-1:0] count_q;
	logic [AW-1:0]      wipe_q;
	logic [PIX_W-1:0]   rdata_q;

	logic               valid_s1;
	logic [SQ_W-1:0]    dx2_s1, dy2_s1;
	logic [AW-1:0]      addr_s1;

	logic               out_valid_q;
	logic [PIX_W-1:0]   pix_q;
	logic               pix_valid_q;
	logic [COUNT_W-1:0] written_q;

	logic [COORD_W-1:0]        w_eff, h_eff;
	logic signed [BND_W-1:0]   w_s, h_s, wm1, hm1;
	logic signed [BND_W-1:0]   cx_e, cy_e, rad_e;
	logic signed [BND_W-1:0]   lo_x, hi_x, lo_y, hi_y;
	logic signed [BND_W-1:0]   x0_c, x1_c, y0_c, y1_c;
	logic signed [BND_W-1:0]   dx_c, dy_c;
	logic signed [2*BND_W-1:0] dxx_c, dyy_c;
	logic [AW+COORD_W-1:0]     addr_w;
	logic [AW-1:0]             addr_c;
	logic                      is_fill, shape_ok, read_ok, wr_en;

	assign w_eff = (BND_W'(canvas_width) > BND_W'(MAX_WIDTH)) ? COORD_W'(MAX_WIDTH) : canvas_width;
	assign h_eff = (BND_W'(canvas_height) > BND_W'(MAX_HEIGHT)) ? COORD_W'(MAX_HEIGHT)
		: canvas_height;
	assign w_s   = $signed(BND_W'(w_eff));
	assign h_s   = $signed(BND_W'(h_eff));
	assign wm1   = w_s - BND_W'(1);
	assign hm1   = h_s - BND_W'(1);

	assign cx_e  = BND_W'(cx_q);
	assign cy_e  = BND_W'(cy_q);
	assign rad_e = BND_W'(rad_q);

	assign is_fill = (op_q == OP_CLEAR);

	always_comb begin
		lo_x = is_fill ? '0  : cx_e - rad_e;
		hi_x = is_fill ? wm1 : cx_e + rad_e;
		lo_y = is_fill ? '0  : cy_e - rad_e;
		hi_y = is_fill ? hm1 : cy_e + rad_e;
		x0_c = lo_x[BND_W-1] ? '0 : lo_x;
		y0_c = lo_y[BND_W-1] ? '0 : lo_y;
		x1_c = (hi_x > wm1) ? wm1 : hi_x;
		y1_c = (hi_y > hm1) ? hm1 : hi_y;
	end

	assign shape_ok = (is_fill || ((op_q == OP_DISC) && !rad_q[8]))
		&& (x0_c <= x1_c) && (y0_c <= y1_c);
	assign read_ok  = (op_q == OP_READ) && !cx_q[8] && !cy_q[8]
		&& (cx_e < w_s) && (cy_e < h_s);

	assign dx_c  = $signed(BND_W'(x_q)) - cx_e;
	assign dy_c  = $signed(BND_W'(y_q)) - cy_e;
	assign dxx_c = dx_c * dx_c;
	assign dyy_c = dy_c * dy_c;

	assign addr_w = ({{AW{1'b0}}, y_q} * (AW+COORD_W)'(MAX_WIDTH)) + (AW+COORD_W)'(x_q);
	assign addr_c = addr_w[AW-1:0];

	assign wr_en = valid_s1
		&& (is_fill || (({1'b0, dx2_s1} + {1'b0, dy2_s1}) <= {1'b0, r2_q}));

	assign sts.wipe_last = (wipe_q == AW'(DEPTH - 1));
	assign sts.scan_go   = shape_ok;
	assign sts.read_go   = read_ok;
	assign sts.scan_last = (x_q == x1_q) && (y_q == y1_q);
	assign sts.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= op;
			cx_q     <= center_x;
			cy_q     <= center_y;
			rad_q    <= radius;
			colour_q <= {paint_alpha, paint_blue, paint_green, paint_red};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			x0_q    <= x0_c[COORD_W-1:0];
			x1_q    <= x1_c[COORD_W-1:0];
			y1_q    <= y1_c[COORD_W-1:0];
			x_q     <= read_ok ? cx_q[COORD_W-1:0] : x0_c[COORD_W-1:0];
			y_q     <= read_ok ? cy_q[COORD_W-1:0] : y0_c[COORD_W-1:0];
			r2_q    <= SQ_W'(rad_q[7:0]) * SQ_W'(rad_q[7:0]);
			rd_ok_q <= read_ok;
			count_q <= '0;
		end else begin
			if (cmd.scan) begin
				if (x_q == x1_q) begin
					x_q <= x0_q;
					y_q <= y_q + COORD_W'(1);
				end else begin
					x_q <= x_q + COORD_W'(1);
				end
			end
			if (wr_en) begin
				count_q <= count_q + COUNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		dx2_s1  <= dxx_c[SQ_W-1:0];
		dy2_s1  <= dyy_c[SQ_W-1:0];
		addr_s1 <= addr_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			wipe_q   <= '0;
		end else begin
			valid_s1 <= cmd.scan;
			if (cmd.wipe) begin
				wipe_q <= wipe_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wipe) begin
			mem[wipe_q] <= '0;
		end else if (wr_en) begin
			mem[addr_s1] <= colour_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rdata_q <= mem[addr_c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			pix_q       <= rd_ok_q ? rdata_q : '0;
			pix_valid_q <= rd_ok_q;
			written_q   <= count_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign pixel_red      = pix_q[7:0];
	assign pixel_green    = pix_q[15:8];
	assign pixel_blue     = pix_q[23:16];
	assign pixel_alpha    = pix_q[31:24];
	assign pixel_valid    = pix_valid_q;
	assign pixels_written = written_q;

endmodule

### hw/rtl/frame_buffer_disc_painter.sv
// RGBA frame buffer of MAX_WIDTH x MAX_HEIGHT pixels with clear, disc and pixel-read
// commands, one result transaction per command. Commands run one at a time through a
// single-write-port frame memory that takes one pixel per cycle: a clear scans the
// whole canvas, a disc its bounding box clamped to the canvas and a read fetches one
// pixel; an unused opcode, a negative radius or an empty box scans nothing. The
// output register lets the next command be accepted while a result waits. After reset
// the memory is swept to zero, all MAX_WIDTH*MAX_HEIGHT words (4096 by default), with
// in_ready low; APB writes of canvas_width (0x0) and canvas_height (0x4) are taken at
// any time.
module frame_buffer_disc_painter import fbdp_pkg::*; #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	input  logic signed [8:0]  center_x,
	input  logic signed [8:0]  center_y,
	input  logic signed [8:0]  radius,
	input  logic [7:0]         paint_red,
	input  logic [7:0]         paint_green,
	input  logic [7:0]         paint_blue,
	input  logic [7:0]         paint_alpha,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         pixel_red,
	output logic [7:0]         pixel_green,
	output logic [7:0]         pixel_blue,
	output logic [7:0]         pixel_alpha,
	output logic               pixel_valid,
	output logic [COUNT_W-1:0] pixels_written
);

	logic [CFG_W-1:0] cfg_width_q, cfg_height_q;
	logic             cfg_wr;
	fbdp_cmd_t        cmd;
	fbdp_sts_t        sts;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_width_q  <= CFG_W'(64);
			cfg_height_q <= CFG_W'(64);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_CANVAS_WIDTH:  cfg_width_q  <= pwdata[CFG_W-1:0];
				REG_CANVAS_HEIGHT: cfg_height_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_CANVAS_WIDTH:  prdata = 32'(cfg_width_q);
			REG_CANVAS_HEIGHT: prdata = 32'(cfg_height_q);
			default:           prdata = '0;
		endcase
	end

	fbdp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	fbdp_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.canvas_width   (cfg_width_q),
		.canvas_height  (cfg_height_q),
		.op             (op),
		.center_x       (center_x),
		.center_y       (center_y),
		.radius         (radius),
		.paint_red      (paint_red),
		.paint_green    (paint_green),
		.paint_blue     (paint_blue),
		.paint_alpha    (paint_alpha),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.pixel_red      (pixel_red),
		.pixel_green    (pixel_green),
		.pixel_blue     (pixel_blue),
		.pixel_alpha    (pixel_alpha),
		.pixel_valid    (pixel_valid),
		.pixels_written (pixels_written)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("command accepted while another is in flight");

	a_read_writes_nothing: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pixel_valid |-> pixels_written == '0)
		else $error("valid read reports written pixels");

	a_blank_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pixel_valid |-> (pixel_red == '0) && (pixel_green == '0)
			&& (pixel_blue == '0) && (pixel_alpha == '0))
		else $error("pixel data without a valid read");

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb;
	import fbdp_pkg::*;

	localparam int MAX_W       = 64;
	localparam int MAX_H       = 64;
	localparam int STALL_LIMIT = 20000;
	localparam int SHOW_LIMIT  = 10;

	typedef struct packed {
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic [7:0]         alpha;
		logic               valid;
		logic [COUNT_W-1:0] written;
	} pixel_result_t;

	class canvas_tracker;
		logic [PIX_W-1:0] frame [0:MAX_W*MAX_H-1];
		logic [CFG_W-1:0] canvas_w;
		logic [CFG_W-1:0] canvas_h;
		pixel_result_t    pending_results [$];
		int               faults;

		function new();
			foreach (frame[i])
				frame[i] = '0;
			canvas_w = 7'd64;
			canvas_h = 7'd64;
			faults = 0;
		endfunction

		function void set_register(logic sel, logic [CFG_W-1:0] value);
			if (sel == REG_CANVAS_WIDTH)
				canvas_w = value;
			else
				canvas_h = value;
		endfunction

		function int pending_count();
			return pending_results.size();
		endfunction

		function pixel_result_t paint_command(logic [1:0] opc, logic signed [8:0] cx,
				logic signed [8:0] cy, logic signed [8:0] rad, logic [31:0] colour);
			pixel_result_t res;
			int w, h, ix, iy, ir, r2, x, y, x0, x1, y0, y1, cnt;
			logic [31:0] p;
			res = '0;
			cnt = 0;
			w = (canvas_w > MAX_W) ? MAX_W : int'(canvas_w);
			h = (canvas_h > MAX_H) ? MAX_H : int'(canvas_h);
			ix = cx;
			iy = cy;
			ir = rad;
			case (opc)
				OP_CLEAR: begin
					for (y = 0; y < h; y++)
						for (x = 0; x < w; x++) begin
							frame[y*MAX_W + x] = colour;
							cnt++;
						end
				end
				OP_DISC: begin
					if (ir >= 0) begin
						r2 = ir * ir;
						y0 = (iy - ir < 0) ? 0 : iy - ir;
						y1 = (iy + ir > h - 1) ? h - 1 : iy + ir;
						x0 = (ix - ir < 0) ? 0 : ix - ir;
						x1 = (ix + ir > w - 1) ? w - 1 : ix + ir;
						for (y = y0; y <= y1; y++)
							for (x = x0; x <= x1; x++)
								if ((x-ix)*(x-ix) + (y-iy)*(y-iy) <= r2) begin
									frame[y*MAX_W + x] = colour;
									cnt++;
								end
					end
				end
				OP_READ: begin
					if (ix >= 0 && ix < w && iy >= 0 && iy < h) begin
						p = frame[iy*MAX_W + ix];
						res.red   = p[7:0];
						res.green = p[15:8];
						res.blue  = p[23:16];
						res.alpha = p[31:24];
						res.valid = 1'b1;
					end
				end
				default: ;
			endcase
			res.written = cnt[COUNT_W-1:0];
			return res;
		endfunction

		function void take_command(logic [1:0] opc, logic signed [8:0] cx,
				logic signed [8:0] cy, logic signed [8:0] rad, logic [31:0] colour);
			pending_results.push_back(paint_command(opc, cx, cy, rad, colour));
		endfunction

		function void match_result(pixel_result_t got);
			pixel_result_t exp_res;
			if (pending_results.size() == 0) begin
				faults++;
				if (faults <= SHOW_LIMIT)
					$display("%0t: result with no command pending: %p", $realtime, got);
				return;
			end
			exp_res = pending_results.pop_front();
			if (got.red !== exp_res.red || got.green !== exp_res.green ||
					got.blue !== exp_res.blue || got.alpha !== exp_res.alpha ||
					got.valid !== exp_res.valid || got.written !== exp_res.written) begin
				faults++;
				if (faults <= SHOW_LIMIT)
					$display("%0t: mismatch exp %h %h %h %h %b %0d got %h %h %h %h %b %0d",
						$realtime, exp_res.red, exp_res.green, exp_res.blue, exp_res.alpha,
						exp_res.valid, exp_res.written, got.red, got.green, got.blue,
						got.alpha, got.valid, got.written);
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [2:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         op = OP_NONE;
	logic signed [8:0]  center_x = '0;
	logic signed [8:0]  center_y = '0;
	logic signed [8:0]  radius = '0;
	logic [7:0]         paint_red = '0;
	logic [7:0]         paint_green = '0;
	logic [7:0]         paint_blue = '0;
	logic [7:0]         paint_alpha = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [7:0]         pixel_red;
	logic [7:0]         pixel_green;
	logic [7:0]         pixel_blue;
	logic [7:0]         pixel_alpha;
	logic               pixel_valid;
	logic [COUNT_W-1:0] pixels_written;

	canvas_tracker tracker;
	int            tx_idle_pct = 16;
	int            rx_idle_pct = 87;
	int            stall_cycles = 0;

	frame_buffer_disc_painter #(
		.MAX_WIDTH(MAX_W),
		.MAX_HEIGHT(MAX_H)
	) uut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.match_result('{pixel_red, pixel_green, pixel_blue, pixel_alpha,
				pixel_valid, pixels_written});
		out_ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	task automatic write_canvas_reg(input logic sel, input logic [CFG_W-1:0] value);
		logic [31-CFG_W:0] junk;
		junk = (32-CFG_W)'($urandom);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= {junk, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		tracker.set_register(sel, value);
	endtask

	task automatic send_command(input logic [1:0] opc, input logic signed [8:0] cx,
			input logic signed [8:0] cy, input logic signed [8:0] rad,
			input logic [31:0] colour);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= opc;
		center_x <= cx;
		center_y <= cy;
		radius <= rad;
		paint_red <= colour[7:0];
		paint_green <= colour[15:8];
		paint_blue <= colour[23:16];
		paint_alpha <= colour[31:24];
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		tracker.take_command(opc, cx, cy, rad, colour);
	endtask

	task automatic random_command();
		int pick, rpick, tmp;
		logic [1:0] opc;
		logic signed [8:0] cx, cy, rad;
		logic [31:0] colour;
		pick = $urandom_range(99);
		colour = $urandom;
		tmp = $urandom;
		cx = tmp[8:0];
		tmp = $urandom;
		cy = tmp[8:0];
		tmp = $urandom;
		rad = tmp[8:0];
		if (pick < 5) begin
			opc = OP_CLEAR;
		end else if (pick < 9) begin
			opc = OP_NONE;
		end else if (pick < 60) begin
			opc = OP_DISC;
			if ($urandom_range(9) != 0) begin
				tmp = $urandom_range(80) - 8;
				cx = tmp[8:0];
				tmp = $urandom_range(80) - 8;
				cy = tmp[8:0];
			end
			rpick = $urandom_range(19);
			if (rpick == 0)
				;
			else if (rpick < 3) begin
				tmp = -int'($urandom_range(8, 1));
				rad = tmp[8:0];
			end else if (rpick < 4) begin
				tmp = $urandom_range(70, 20);
				rad = tmp[8:0];
			end else begin
				tmp = $urandom_range(12);
				rad = tmp[8:0];
			end
		end else begin
			opc = OP_READ;
			if ($urandom_range(7) != 0) begin
				tmp = $urandom_range(71) - 2;
				cx = tmp[8:0];
				tmp = $urandom_range(71) - 2;
				cy = tmp[8:0];
			end
		end
		send_command(opc, cx, cy, rad, colour);
	endtask

	initial begin
		int phase_w [7];
		int phase_h [7];
		int phase_n [7];
		int w, h;
		tracker = new();
		phase_w = '{64, 0, 127, 1, 64, 127, -1};
		phase_h = '{64, 3, 0, 1, 127, 40, -1};
		phase_n = '{20, 5, 5, 8, 25, 25, 28};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		send_command(OP_READ, 9'sd0, 9'sd0, 9'sd0, 32'h0000_0000);
		send_command(OP_READ, 9'sd63, 9'sd63, 9'sd0, 32'hFFFF_FFFF);
		send_command(OP_CLEAR, 9'sd0, 9'sd0, 9'sd0, 32'hFFFF_FFFF);
		send_command(OP_READ, 9'sd63, 9'sd63, 9'sd0, 32'h0000_0000);
		send_command(OP_DISC, 9'sd0, 9'sd0, 9'sd0, 32'h55AA_55AA);
		send_command(OP_READ, 9'sd0, 9'sd0, 9'sd0, 32'h0000_0000);
		send_command(OP_DISC, 9'sd10, 9'sd10, -9'sd1, 32'h1234_5678);
		send_command(OP_DISC, 9'sd10, 9'sd10, -9'sd256, 32'h1234_5678);
		send_command(OP_DISC, 9'sd32, 9'sd32, 9'sd255, 32'hA55A_A55A);
		send_command(OP_DISC, -9'sd256, -9'sd256, 9'sd255, 32'h0F0F_0F0F);
		send_command(OP_DISC, 9'sd255, 9'sd255, 9'sd255, 32'hF0F0_F0F0);
		send_command(OP_DISC, -9'sd3, 9'sd70, 9'sd9, 32'h0102_0304);
		send_command(OP_READ, -9'sd1, 9'sd0, 9'sd0, 32'h0000_0000);
		send_command(OP_READ, 9'sd64, 9'sd0, 9'sd0, 32'h0000_0000);
		send_command(OP_READ, 9'sd0, 9'sd64, 9'sd0, 32'h0000_0000);
		send_command(OP_READ, -9'sd256, -9'sd256, -9'sd256, 32'hFFFF_FFFF);
		send_command(OP_READ, 9'sd255, 9'sd255, 9'sd255, 32'hFFFF_FFFF);
		send_command(OP_READ, 9'sd0, 9'sd63, 9'sd0, 32'h0000_0000);
		send_command(OP_NONE, 9'sd5, 9'sd5, 9'sd5, 32'hDEAD_BEEF);
		send_command(OP_CLEAR, 9'sd0, 9'sd0, 9'sd0, 32'h0000_0000);
		send_command(OP_DISC, 9'sd20, 9'sd40, 9'sd7, 32'h1234_5678);
		send_command(OP_READ, 9'sd20, 9'sd40, 9'sd0, 32'h0000_0000);
		send_command(OP_READ, 9'sd27, 9'sd40, 9'sd0, 32'h0000_0000);
		send_command(OP_READ, 9'sd28, 9'sd40, 9'sd0, 32'h0000_0000);

		for (int p = 0; p < 7; p++) begin
			in_valid <= 1'b0;
			// registers only change with the pipeline drained
			while (tracker.pending_count() != 0)
				@(posedge clk);
			if (p == 3) begin
				tx_idle_pct = 87;
				rx_idle_pct = 16;
			end else if (p == 5) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			w = (phase_w[p] < 0) ? $urandom_range(127) : phase_w[p];
			h = (phase_h[p] < 0) ? $urandom_range(127) : phase_h[p];
			write_canvas_reg(REG_CANVAS_WIDTH, w[CFG_W-1:0]);
			write_canvas_reg(REG_CANVAS_HEIGHT, h[CFG_W-1:0]);
			repeat (phase_n[p])
				random_command();
		end

		in_valid <= 1'b0;
		while (tracker.pending_count() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (tracker.faults == 0 && tracker.pending_count() == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

### frame_buffer_disc_painter.f
hw/rtl/fbdp_pkg.sv
hw/rtl/fbdp_ctrl.sv
hw/rtl/fbdp_datapath.sv
hw/rtl/frame_buffer_disc_painter.sv
sim/tb.sv
